// File: sv/dhcpf_pkg.sv
`timescale 1ns / 1ps
package dhcpf_pkg;

  // one frame byte in wire order
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_item_t;

  // verdict for one frame
  typedef struct packed {
    logic       accept;
    logic [7:0] message_type;
  } result_item_t;

  // configuration register values
  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [10:0] min_frame_length;
  } cfg_t;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_MAC          = 2'd0;
  localparam logic [1:0] REG_OWN_IP           = 2'd1;
  localparam logic [1:0] REG_MIN_FRAME_LENGTH = 2'd2;

  localparam logic [10:0] MIN_FRAME_LENGTH_RESET = 11'd278;

  // frame layout
  localparam int unsigned DST_MAC_BYTES   = 6;
  localparam int unsigned ETYPE_HI_POS    = 12;
  localparam int unsigned ETYPE_LO_POS    = 13;
  localparam int unsigned IHL_POS         = 14;
  localparam int unsigned PROTO_POS       = 23;
  localparam int unsigned IP_FIXED_END    = 24;
  localparam int unsigned ETH_HDR_BYTES   = 14;
  localparam int unsigned UDP_HDR_BYTES   = 8;
  localparam int unsigned DHCP_FIXED_BODY = 236;
  localparam int unsigned COOKIE_BYTES    = 4;

  // field values
  localparam logic [7:0] BCAST_BYTE    = 8'hFF;
  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [3:0] MIN_IHL       = 4'd5;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PORT_HI       = 8'd0;
  localparam logic [7:0] CLIENT_PORT   = 8'd68;
  localparam logic [7:0] SERVER_PORT   = 8'd67;
  localparam logic [7:0] COOKIE_B0     = 8'h63;
  localparam logic [7:0] COOKIE_B1     = 8'h82;
  localparam logic [7:0] COOKIE_B2     = 8'h53;
  localparam logic [7:0] COOKIE_B3     = 8'h63;

  // option codes
  localparam logic [7:0] OPT_END       = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;

  // checks_passed bits
  localparam int unsigned CHK_BCAST  = 0;
  localparam int unsigned CHK_OWNMAC = 1;
  localparam int unsigned CHK_ETYPE  = 2;
  localparam int unsigned CHK_IHL    = 3;
  localparam int unsigned CHK_PROTO  = 4;
  localparam int unsigned CHK_UDP    = 5;

endpackage

// File: sv/dhcpf_cfg.sv
`timescale 1ns / 1ps
module dhcpf_cfg
  import dhcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [47:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac          <= '0;
      cfg.own_ip           <= '0;
      cfg.min_frame_length <= MIN_FRAME_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OWN_MAC:          cfg.own_mac          <= wr_data;
        REG_OWN_IP:           cfg.own_ip           <= wr_data[31:0];
        REG_MIN_FRAME_LENGTH: cfg.min_frame_length <= wr_data[10:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/dhcpf_parse.sv
`timescale 1ns / 1ps
module dhcpf_parse
  import dhcpf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  frame_item_t  item,
  input  cfg_t         cfg,
  output result_item_t result
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int PW1   = POS_W + 1;
  localparam int CMP_W = (PW1 > 11) ? PW1 : 11;
  localparam logic [POS_W-1:0] LIMIT = POS_W'(MAX_FRAME_BYTES - 1);

  // frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [3:0]       header_words, header_words_next;
  logic [5:0]       checks_passed, checks_passed_next;
  logic [POS_W-1:0] next_option_start, next_option_start_next;
  logic             option_phase, option_phase_next;
  logic             options_ended, options_ended_next;
  logic             type_found, type_found_next;
  logic [7:0]       type_value, type_value_next;
  logic             type_armed, type_armed_next;
  logic [PW1-1:0]   type_at, type_at_next;
  logic             server_id_seen, server_id_seen_next;
  logic [31:0]      server_id_bytes, server_id_bytes_next;
  logic             sid_armed, sid_armed_next;
  logic [PW1-1:0]   sid_at, sid_at_next;

  logic [7:0]     b;
  logic [PW1-1:0] pw;
  logic [PW1-1:0] udp, cookie, opts, cookie_end, nxt, sid_off, eff_nos;
  logic           at_opts, eff_phase, examine;
  logic [7:0]     mac_byte;
  logic           ok;

  assign b  = item.frame_byte;
  assign pw = {1'b0, byte_position};

  assign udp     = PW1'(ETH_HDR_BYTES) + PW1'({header_words, 2'b00});
  assign cookie  = udp + PW1'(UDP_HDR_BYTES + DHCP_FIXED_BODY);
  assign opts    = cookie + PW1'(COOKIE_BYTES);
  assign at_opts = (pw == opts);
  assign sid_off = pw - sid_at;
  assign examine = step && (byte_position < LIMIT);

  always_comb begin
    case (byte_position[2:0])
      3'd0:    mac_byte = cfg.own_mac[47:40];
      3'd1:    mac_byte = cfg.own_mac[39:32];
      3'd2:    mac_byte = cfg.own_mac[31:24];
      3'd3:    mac_byte = cfg.own_mac[23:16];
      3'd4:    mac_byte = cfg.own_mac[15:8];
      default: mac_byte = cfg.own_mac[7:0];
    endcase
  end

  always_comb begin
    byte_position_next     = byte_position;
    header_words_next      = header_words;
    checks_passed_next     = checks_passed;
    next_option_start_next = next_option_start;
    option_phase_next      = option_phase;
    options_ended_next     = options_ended;
    type_found_next        = type_found;
    type_value_next        = type_value;
    type_armed_next        = type_armed;
    type_at_next           = type_at;
    server_id_seen_next    = server_id_seen;
    server_id_bytes_next   = server_id_bytes;
    sid_armed_next         = sid_armed;
    sid_at_next            = sid_at;
    eff_phase              = at_opts ? 1'b0 : option_phase;
    eff_nos                = at_opts ? opts : {1'b0, next_option_start};
    nxt                    = pw + PW1'(1) + PW1'(b);
    cookie_end             = '0;
    ok                     = 1'b0;
    result                 = '0;

    if (examine) begin
      if (pw < PW1'(DST_MAC_BYTES)) begin
        if (b != BCAST_BYTE) checks_passed_next[CHK_BCAST] = 1'b0;
        if (b != mac_byte)   checks_passed_next[CHK_OWNMAC] = 1'b0;
      end else if (pw == PW1'(IHL_POS)) begin
        header_words_next = b[3:0];
        if (b[3:0] < MIN_IHL) checks_passed_next[CHK_IHL] = 1'b0;
      end else begin
        if ((pw == PW1'(ETYPE_HI_POS) && b != ETYPE_IPV4_HI) ||
            (pw == PW1'(ETYPE_LO_POS) && b != ETYPE_IPV4_LO))
          checks_passed_next[CHK_ETYPE] = 1'b0;
        if (pw == PW1'(PROTO_POS) && b != PROTO_UDP)
          checks_passed_next[CHK_PROTO] = 1'b0;

        if (pw >= PW1'(IP_FIXED_END)) begin
          // udp ports and magic cookie
          if ((pw == udp && b != PORT_HI) ||
              (pw == udp + PW1'(1) && b != CLIENT_PORT) ||
              (pw == udp + PW1'(2) && b != PORT_HI) ||
              (pw == udp + PW1'(3) && b != SERVER_PORT))
            checks_passed_next[CHK_UDP] = 1'b0;
          if ((pw == cookie && b != COOKIE_B0) ||
              (pw == cookie + PW1'(1) && b != COOKIE_B1) ||
              (pw == cookie + PW1'(2) && b != COOKIE_B2) ||
              (pw == cookie + PW1'(3) && b != COOKIE_B3))
            checks_passed_next[CHK_UDP] = 1'b0;

          // option value capture
          if (type_armed && pw == type_at) begin
            type_value_next = b;
            type_armed_next = 1'b0;
          end
          if (sid_armed && pw >= sid_at && sid_off < PW1'(4)) begin
            case (sid_off[1:0])
              2'd0:    server_id_bytes_next[31:24] = server_id_bytes[31:24] | b;
              2'd1:    server_id_bytes_next[23:16] = server_id_bytes[23:16] | b;
              2'd2:    server_id_bytes_next[15:8]  = server_id_bytes[15:8] | b;
              default: server_id_bytes_next[7:0]   = server_id_bytes[7:0] | b;
            endcase
            if (sid_off[1:0] == 2'd3) sid_armed_next = 1'b0;
          end

          // option tlv walk
          if (at_opts) begin
            next_option_start_next = opts[POS_W-1:0];
            option_phase_next      = 1'b0;
          end
          if (pw >= opts && !options_ended) begin
            if (!eff_phase) begin
              if (pw == eff_nos) begin
                if (b == OPT_END) begin
                  options_ended_next = 1'b1;
                end else begin
                  if (b == OPT_MSG_TYPE && !type_found) begin
                    type_found_next = 1'b1;
                    type_armed_next = 1'b1;
                    type_at_next    = pw + PW1'(2);
                  end
                  if (b == OPT_SERVER_ID && !server_id_seen) begin
                    server_id_seen_next = 1'b1;
                    sid_armed_next      = 1'b1;
                    sid_at_next         = pw + PW1'(2);
                  end
                  option_phase_next = 1'b1;
                end
              end
            end else begin
              if (nxt > {1'b0, LIMIT}) next_option_start_next = LIMIT;
              else                     next_option_start_next = nxt[POS_W-1:0];
              option_phase_next = 1'b0;
            end
          end
        end
      end
    end

    if (step && item.last_byte) begin
      cookie_end = PW1'(ETH_HDR_BYTES + UDP_HDR_BYTES + DHCP_FIXED_BODY + 3) +
                   PW1'({header_words_next, 2'b00});
      ok = (checks_passed_next[CHK_OWNMAC:CHK_BCAST] != 2'b00) &&
           (&checks_passed_next[CHK_UDP:CHK_ETYPE]) &&
           (cookie_end <= pw) && (cookie_end < {1'b0, LIMIT}) &&
           (CMP_W'(pw) + CMP_W'(1) >= CMP_W'(cfg.min_frame_length)) &&
           !(server_id_seen_next && server_id_bytes_next != cfg.own_ip);
      result.accept       = ok;
      result.message_type = type_value_next;

      // start over for the next frame
      byte_position_next     = '0;
      header_words_next      = '0;
      checks_passed_next     = '1;
      next_option_start_next = '0;
      option_phase_next      = 1'b0;
      options_ended_next     = 1'b0;
      type_found_next        = 1'b0;
      type_value_next        = '0;
      type_armed_next        = 1'b0;
      type_at_next           = '0;
      server_id_seen_next    = 1'b0;
      server_id_bytes_next   = '0;
      sid_armed_next         = 1'b0;
      sid_at_next            = '0;
    end else if (examine) begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_words      <= '0;
      checks_passed     <= '1;
      next_option_start <= '0;
      option_phase      <= 1'b0;
      options_ended     <= 1'b0;
      type_found        <= 1'b0;
      type_value        <= '0;
      type_armed        <= 1'b0;
      type_at           <= '0;
      server_id_seen    <= 1'b0;
      server_id_bytes   <= '0;
      sid_armed         <= 1'b0;
      sid_at            <= '0;
    end else begin
      byte_position     <= byte_position_next;
      header_words      <= header_words_next;
      checks_passed     <= checks_passed_next;
      next_option_start <= next_option_start_next;
      option_phase      <= option_phase_next;
      options_ended     <= options_ended_next;
      type_found        <= type_found_next;
      type_value        <= type_value_next;
      type_armed        <= type_armed_next;
      type_at           <= type_at_next;
      server_id_seen    <= server_id_seen_next;
      server_id_bytes   <= server_id_bytes_next;
      sid_armed         <= sid_armed_next;
      sid_at            <= sid_at_next;
    end
  end

endmodule

// File: sv/dhcp_request_frame_filter.sv
`timescale 1ns / 1ps
// DHCP request frame filter. Takes an Ethernet frame one byte per transfer and,
// on the transfer carrying last_byte, emits one result: accept is high when the
// frame is a client DHCP packet for this server (destination broadcast or
// own_mac, IPv4/UDP with IHL of at least 5, ports 68 to 67 at 14 + 4*IHL, magic
// cookie present, length at least min_frame_length, and the first server
// identifier option, if any, equal to own_ip); message_type is the value of the
// first message-type option, or 0 when there is none. The block takes one byte
// every cycle with no gaps needed: a byte is registered on input, examined by a
// combinational parser against the running frame state, and the verdict lands
// in the result register. The input stalls only when a verdict is due while the
// previous one is still held by a stalled output. Byte positions count up to
// MAX_FRAME_BYTES - 1 and hold there; bytes from that position on are ignored.
// Configuration registers, index 0 own_mac, 1 own_ip, 2 min_frame_length
// (reset 278), are written through cfg_valid/cfg_ready (always ready) while the
// block is idle; this is up to the user, as the block has no check for it.
module dhcp_request_frame_filter
  import dhcpf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic         clk,
  input  logic         rst,
  // frame byte stream
  input  logic         frame_valid,
  output logic         frame_stall,
  input  frame_item_t  frame,
  // verdict stream
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  cfg_t         cfg;
  logic         s1_valid;
  frame_item_t  s1_item;
  logic         blocked;
  logic         step;
  logic         take;
  result_item_t verdict;

  // registers are always writable
  assign cfg_ready = 1'b1;

  dhcpf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a last byte cannot move on while the previous verdict sits unclaimed
  assign blocked     = s1_valid && s1_item.last_byte && result_valid && result_stall;
  assign frame_stall = blocked;
  assign step        = s1_valid && !blocked;
  assign take        = frame_valid && !frame_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= frame;
    end
  end

  dhcpf_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && s1_item.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_item.last_byte) begin
      result <= verdict;
    end
  end

  // a verdict only appears after a last byte went through the parser
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step && s1_item.last_byte))
    else $error("result without a last byte");

  // the input only stalls behind a held verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (result_valid && result_stall && s1_valid))
    else $error("input stalled without a held verdict");

  // a blocked byte stays in the input register
  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    blocked |=> (s1_valid && $stable(s1_item)))
    else $error("blocked byte lost");

endmodule
